/* sv/siet_pkg.sv */
// ----------------------------------------------------------------------------
// siet_pkg: shared definitions of the sorted insertion event table
// Table depth, field widths, limits of the date and time fields, result kinds
// and the records that pass between the table sequencer and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package siet_pkg;

    localparam int DEPTH = 32;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 56;
    localparam int KIND_W      = 3;

    localparam logic [6:0] MONTH_DUMP = 7'd0;
    localparam logic [6:0] MONTH_MAX  = 7'd12;
    localparam logic [6:0] DAY_MAX    = 7'd31;
    localparam logic [6:0] HOUR_MAX   = 7'd23;
    localparam logic [6:0] MINUTE_MAX = 7'd59;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [KIND_W-1:0] {
        KIND_STORED   = 3'd0,
        KIND_BAD_DATE = 3'd1,
        KIND_BAD_TIME = 3'd2,
        KIND_ENTRY    = 3'd3,
        KIND_END      = 3'd4
    } t_kind;

    typedef struct packed {
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [31:0] payload;
    } t_in_item;

    // Month in the top bits, so the packed key orders by date and then time.
    typedef struct packed {
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
    } t_key;

    typedef struct packed {
        t_key        key;
        logic [31:0] payload;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_kind  kind;
        t_entry entry;
        logic   last;
    } t_beat;

endpackage

`default_nettype wire

/* sv/siet_table.sv */
// ----------------------------------------------------------------------------
// siet_table: entry memory and insert/dump sequencer
// Holds the sorted entries in a synchronous memory. An insert sweeps down from
// the top entry, moving each larger or equal entry up by one until the slot of
// the new entry is found. A dump reads the entries in order and hands one beat
// per entry to the output stage, followed by the end marker.
// ----------------------------------------------------------------------------
`default_nettype none

module siet_table (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire siet_pkg::t_in_item i_item,
    input  wire logic              i_out_free,
    output siet_pkg::t_beat        o_beat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_IREAD,
        S_ICMP,
        S_STORED,
        S_DREAD,
        S_DWAIT,
        S_DEND,
        S_EMIT1
    } t_state;

    t_state           r_state, n_state;
    siet_pkg::t_cnt   r_count, n_count;
    siet_pkg::t_idx   r_j, n_j;
    siet_pkg::t_idx   r_idx, n_idx;
    siet_pkg::t_entry r_new, n_new;
    siet_pkg::t_kind  r_kind, n_kind;

    siet_pkg::t_entry r_mem [siet_pkg::DEPTH];
    siet_pkg::t_entry r_rdata;
    logic             mem_we;
    siet_pkg::t_idx   mem_waddr;
    siet_pkg::t_entry mem_wdata;
    logic             mem_re;
    siet_pkg::t_idx   mem_raddr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_j       = r_j;
        n_idx     = r_idx;
        n_new     = r_new;
        n_kind    = r_kind;
        o_ready   = 1'b0;
        o_beat    = '0;
        mem_we    = 1'b0;
        mem_waddr = r_j;
        mem_wdata = r_new;
        mem_re    = 1'b0;
        mem_raddr = r_idx;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_new.key.month  = i_item.month[3:0];
                    n_new.key.day    = i_item.day[4:0];
                    n_new.key.hour   = i_item.hour[4:0];
                    n_new.key.minute = i_item.minute[5:0];
                    n_new.payload    = i_item.payload;
                    if (i_item.month == siet_pkg::MONTH_DUMP) begin
                        n_idx   = '0;
                        n_state = (r_count == '0) ? S_DEND : S_DREAD;
                    end else if (i_item.month > siet_pkg::MONTH_MAX ||
                                 i_item.day > siet_pkg::DAY_MAX) begin
                        n_kind  = siet_pkg::KIND_BAD_DATE;
                        n_state = S_EMIT1;
                    end else if (i_item.hour > siet_pkg::HOUR_MAX ||
                                 i_item.minute > siet_pkg::MINUTE_MAX) begin
                        n_kind  = siet_pkg::KIND_BAD_TIME;
                        n_state = S_EMIT1;
                    end else begin
                        n_j     = r_count[siet_pkg::IDX_W-1:0];
                        n_state = S_IREAD;
                    end
                end
            end
            S_IREAD: begin
                if (r_j == '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    mem_wdata = r_new;
                    n_count   = r_count + siet_pkg::t_cnt'(1);
                    n_state   = S_STORED;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_j - siet_pkg::t_idx'(1);
                    n_state   = S_ICMP;
                end
            end
            S_ICMP: begin
                mem_we    = 1'b1;
                mem_waddr = r_j;
                if (r_rdata.key >= r_new.key) begin
                    mem_wdata = r_rdata;
                    n_j       = r_j - siet_pkg::t_idx'(1);
                    n_state   = S_IREAD;
                end else begin
                    mem_wdata = r_new;
                    n_count   = r_count + siet_pkg::t_cnt'(1);
                    n_state   = S_STORED;
                end
            end
            S_STORED: begin
                if (i_out_free) begin
                    o_beat.valid = 1'b1;
                    o_beat.kind  = siet_pkg::KIND_STORED;
                    if (r_count == siet_pkg::t_cnt'(siet_pkg::DEPTH)) begin
                        o_beat.last = 1'b0;
                        n_idx       = '0;
                        n_state     = S_DREAD;
                    end else begin
                        o_beat.last = 1'b1;
                        n_state     = S_IDLE;
                    end
                end
            end
            S_DREAD: begin
                mem_re    = 1'b1;
                mem_raddr = r_idx;
                n_state   = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_out_free) begin
                    o_beat.valid = 1'b1;
                    o_beat.kind  = siet_pkg::KIND_ENTRY;
                    o_beat.entry = r_rdata;
                    n_idx        = r_idx + siet_pkg::t_idx'(1);
                    if (siet_pkg::t_cnt'(r_idx) + siet_pkg::t_cnt'(1) == r_count) begin
                        n_state = S_DEND;
                    end else begin
                        n_state = S_DREAD;
                    end
                end
            end
            S_DEND: begin
                if (i_out_free) begin
                    o_beat.valid = 1'b1;
                    o_beat.kind  = siet_pkg::KIND_END;
                    o_beat.last  = 1'b1;
                    n_count      = '0;
                    n_state      = S_IDLE;
                end
            end
            S_EMIT1: begin
                if (i_out_free) begin
                    o_beat.valid = 1'b1;
                    o_beat.kind  = r_kind;
                    o_beat.last  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_j    <= n_j;
        r_idx  <= n_idx;
        r_new  <= n_new;
        r_kind <= n_kind;
    end

    a_count_below_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_count < siet_pkg::t_cnt'(siet_pkg::DEPTH))
        else $error("Entry count reached the depth while idle.");

    a_write_in_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_IREAD || r_state == S_ICMP))
        else $error("Memory written outside an insert sweep.");

    a_beat_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_beat.valid |-> i_out_free)
        else $error("Beat issued while the output stage was full.");

    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("Second item taken before the first was finished.");

endmodule

`default_nettype wire

/* sv/siet_obuf.sv */
// ----------------------------------------------------------------------------
// siet_obuf: output register
// Holds one result beat for the output stream and packs it onto the bus, so
// the sequencer can move on while the beat waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module siet_obuf (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire siet_pkg::t_beat                       i_beat,
    output logic                                       o_free,
    output logic                                       o_tvalid,
    input  wire logic                                  i_tready,
    output logic [siet_pkg::OUT_TDATA_W-1:0]           o_tdata,
    output logic [siet_pkg::KIND_W-1:0]                o_tuser,
    output logic                                       o_tlast
);

    logic            r_valid;
    siet_pkg::t_beat r_beat;

    assign o_free = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_beat.valid) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
        if (i_beat.valid) begin
            r_beat <= i_beat;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tuser  = r_beat.kind;
    assign o_tlast  = r_beat.last;
    assign o_tdata  = {4'b0000,
                       r_beat.entry.payload,
                       r_beat.entry.key.minute,
                       r_beat.entry.key.hour,
                       r_beat.entry.key.day,
                       r_beat.entry.key.month};

endmodule

`default_nettype wire

/* sv/sorted_insertion_event_table_top.sv */
// ----------------------------------------------------------------------------
// sorted_insertion_event_table_top: time-sorted event table
// Each input beat carries a date, a time and a payload tag; valid entries are
// kept in a memory sorted by time, a new entry ahead of equal keys. Month 0,
// or the insert that fills the table, lists every entry in order, then an end
// marker, and empties the table. One item is handled at a time and the
// memory's single read port sets the pace: an insert reads and moves each
// entry at or after its place in turn, and a dump reads the entries one by
// one. Stalls on the output stream hold the sequencer back. The last result
// beat is held in an output register, so the next item is taken while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_insertion_event_table_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // month [6:0], day [13:7], hour [20:14], minute [27:21], payload [59:28]
    input  wire logic [siet_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // entry_month [3:0], entry_day [8:4], entry_hour [13:9],
    // entry_minute [19:14], entry_payload [51:20]
    output logic [siet_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // kind [2:0]
    output logic [siet_pkg::KIND_W-1:0]            m_axis_tuser,
    output logic                                   m_axis_tlast
);

    siet_pkg::t_in_item in_item;
    siet_pkg::t_beat    beat;
    logic               out_free;

    assign in_item.month   = s_axis_tdata[6:0];
    assign in_item.day     = s_axis_tdata[13:7];
    assign in_item.hour    = s_axis_tdata[20:14];
    assign in_item.minute  = s_axis_tdata[27:21];
    assign in_item.payload = s_axis_tdata[59:28];

    siet_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_item     (in_item),
        .i_out_free (out_free),
        .o_beat     (beat)
    );

    siet_obuf u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_beat   (beat),
        .o_free   (out_free),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

/* sim/tb_sorted_insertion_event_table_top.sv */
// ----------------------------------------------------------------------------
// tb_sorted_insertion_event_table_top: self-checking bench of the event table
// Items are driven on the input stream and the result stream is compared,
// beat by beat, with the beats predicted from a time-sorted table kept in a
// scoreboard. Directed items cover dumps of an empty table, rejected dates
// and times, field extremes and equal keys. Random bursts of well-formed
// inserts with some rejects then fill the table and dump it. Both streams
// idle at random, and one long output hold-off backs the block up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sorted_insertion_event_table_top;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 140;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 200;
    localparam int IDLE_PCT     = 6;

    typedef struct packed {
        siet_pkg::t_kind  kind;
        siet_pkg::t_entry entry;
        logic             last;
    } t_expect;

    class sorted_table_scoreboard;
        siet_pkg::t_entry table_rows[siet_pkg::DEPTH];
        int unsigned      fill = 0;
        t_expect          due_results[$];
        int unsigned      errors = 0;
        int unsigned      items_noted = 0;
        int unsigned      beats_checked = 0;
        int unsigned      inserts = 0;
        int unsigned      rejects = 0;
        int unsigned      dumps = 0;
        int unsigned      full_dumps = 0;

        function void queue_result(siet_pkg::t_kind kind, siet_pkg::t_entry entry,
                                   logic last);
            t_expect e;
            e.kind  = kind;
            e.entry = entry;
            e.last  = last;
            due_results.push_back(e);
        endfunction

        function void queue_dump();
            for (int i = 0; i < fill; i++) begin
                queue_result(siet_pkg::KIND_ENTRY, table_rows[i], 1'b0);
            end
            queue_result(siet_pkg::KIND_END, '0, 1'b1);
            fill = 0;
            dumps++;
        endfunction

        function void note_item(siet_pkg::t_in_item it);
            siet_pkg::t_entry row;
            int               pos;
            items_noted++;
            if (it.month == siet_pkg::MONTH_DUMP) begin
                queue_dump();
            end else if (it.month > siet_pkg::MONTH_MAX || it.day > siet_pkg::DAY_MAX) begin
                queue_result(siet_pkg::KIND_BAD_DATE, '0, 1'b1);
                rejects++;
            end else if (it.hour > siet_pkg::HOUR_MAX ||
                         it.minute > siet_pkg::MINUTE_MAX) begin
                queue_result(siet_pkg::KIND_BAD_TIME, '0, 1'b1);
                rejects++;
            end else begin
                row.key.month  = it.month[3:0];
                row.key.day    = it.day[4:0];
                row.key.hour   = it.hour[4:0];
                row.key.minute = it.minute[5:0];
                row.payload    = it.payload;
                pos = 0;
                while (pos < fill && table_rows[pos].key < row.key) pos++;
                for (int j = fill; j > pos; j--) table_rows[j] = table_rows[j-1];
                table_rows[pos] = row;
                fill++;
                inserts++;
                queue_result(siet_pkg::KIND_STORED, '0, fill != siet_pkg::DEPTH);
                if (fill == siet_pkg::DEPTH) begin
                    full_dumps++;
                    queue_dump();
                end
            end
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("beat %0d %s: got 0x%0h, expected 0x%0h",
                                          beats_checked, name, got, want));
        endtask

        task check_beat(logic [siet_pkg::KIND_W-1:0] kind,
                        logic [siet_pkg::OUT_TDATA_W-1:0] data, logic last);
            t_expect want;
            beats_checked++;
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("beat %0d arrived with nothing outstanding",
                                          beats_checked));
                return;
            end
            want = due_results.pop_front();
            check_field("kind",          32'(kind),         32'(want.kind));
            check_field("entry_month",   32'(data[3:0]),    32'(want.entry.key.month));
            check_field("entry_day",     32'(data[8:4]),    32'(want.entry.key.day));
            check_field("entry_hour",    32'(data[13:9]),   32'(want.entry.key.hour));
            check_field("entry_minute",  32'(data[19:14]),  32'(want.entry.key.minute));
            check_field("entry_payload", data[51:20],       want.entry.payload);
            check_field("last",          32'(last),         32'(want.last));
        endtask
    endclass

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    logic [siet_pkg::IN_TDATA_W-1:0]     s_axis_tdata;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready;
    logic [siet_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;
    logic [siet_pkg::KIND_W-1:0]         m_axis_tuser;
    logic                                m_axis_tlast;

    bit calm = 1'b0;
    bit hold_req = 1'b0;

    sorted_table_scoreboard book = new;

    sorted_insertion_event_table_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    function automatic siet_pkg::t_in_item make_item(int mo, int dy, int hr, int mi,
                                                     logic [31:0] pay);
        siet_pkg::t_in_item it;
        it.month   = 7'(mo);
        it.day     = 7'(dy);
        it.hour    = 7'(hr);
        it.minute  = 7'(mi);
        it.payload = pay;
        return it;
    endfunction

    // A narrow item draws from a handful of keys so that equal keys are common.
    function automatic siet_pkg::t_in_item good_item(bit narrow);
        if (narrow)
            return make_item($urandom_range(3, 4), $urandom_range(1), $urandom_range(1),
                             $urandom_range(1), $urandom);
        return make_item($urandom_range(1, 12), $urandom_range(31), $urandom_range(23),
                         $urandom_range(59), $urandom);
    endfunction

    function automatic siet_pkg::t_in_item bad_date_item();
        if ($urandom_range(1))
            return make_item($urandom_range(13, 127), $urandom_range(127),
                             $urandom_range(127), $urandom_range(127), $urandom);
        return make_item($urandom_range(1, 12), $urandom_range(32, 127),
                         $urandom_range(127), $urandom_range(127), $urandom);
    endfunction

    function automatic siet_pkg::t_in_item bad_time_item();
        if ($urandom_range(1))
            return make_item($urandom_range(1, 12), $urandom_range(31),
                             $urandom_range(24, 127), $urandom_range(127), $urandom);
        return make_item($urandom_range(1, 12), $urandom_range(31),
                         $urandom_range(23), $urandom_range(60, 127), $urandom);
    endfunction

    function automatic siet_pkg::t_in_item dump_item();
        return make_item(siet_pkg::MONTH_DUMP, $urandom_range(127), $urandom_range(127),
                         $urandom_range(127), $urandom);
    endfunction

    task automatic send_item(siet_pkg::t_in_item it);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, it.payload, it.minute, it.hour, it.day, it.month};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        book.note_item(it);
    endtask

    initial begin : result_sink
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            book.check_beat(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no beat accepted for %0d cycles.", STALL_LIMIT);
        $display("sorted_insertion_event_table_top verification failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned sent;
        int unsigned burst;
        int unsigned pick;
        bit          first;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Dumps of an empty table give the end marker alone.
        send_item(make_item(0, 0, 0, 0, 32'h0));
        send_item(make_item(0, 127, 127, 127, 32'hFFFF_FFFF));
        // Rejected dates, including one whose time is also bad.
        send_item(make_item(13, 1, 1, 1, 32'h1));
        send_item(make_item(127, 127, 127, 127, 32'hFFFF_FFFF));
        send_item(make_item(5, 32, 10, 10, 32'h2));
        send_item(make_item(12, 127, 99, 99, 32'h3));
        // Rejected times.
        send_item(make_item(7, 15, 24, 0, 32'h4));
        send_item(make_item(7, 15, 0, 60, 32'h5));
        send_item(make_item(1, 0, 127, 127, 32'h6));
        // Extremes, then equal keys where the newer entry must come first.
        send_item(make_item(12, 31, 23, 59, 32'hFFFF_FFFF));
        send_item(make_item(1, 0, 0, 0, 32'h0));
        send_item(make_item(6, 15, 12, 30, 32'hAAAA_0001));
        send_item(make_item(6, 15, 12, 30, 32'h5555_0002));
        send_item(make_item(6, 15, 12, 29, 32'h1234_5678));
        send_item(dump_item());

        // Bursts of inserts with some rejects; the first burst fills the table.
        sent  = 0;
        first = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            burst = first ? siet_pkg::DEPTH : $urandom_range(6, siet_pkg::DEPTH + 4);
            for (int i = 0; i < burst; i++) begin
                pick = $urandom_range(99);
                if (first || pick >= 16)
                    send_item(good_item($urandom_range(99) < 30));
                else if (pick < 8)
                    send_item(bad_date_item());
                else
                    send_item(bad_time_item());
                sent++;
                if (sent == 60) calm = 1'b1;
                if (sent == 100) calm = 1'b0;
                if (sent == 120) hold_req = 1'b1;
            end
            first = 1'b0;
            if ($urandom_range(1)) begin
                send_item(dump_item());
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (book.due_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d items: %0d inserts, %0d rejects, %0d dumps (%0d on a full table).",
                 book.items_noted, book.inserts, book.rejects, book.dumps, book.full_dumps);
        $display("Checked %0d result beats with %0d mismatches.",
                 book.beats_checked, book.errors);
        if (book.errors == 0)
            $display("sorted_insertion_event_table_top verification clean");
        else
            $display("sorted_insertion_event_table_top verification failed");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
sv/siet_pkg.sv
sv/siet_table.sv
sv/siet_obuf.sv
sv/sorted_insertion_event_table_top.sv
sim/tb_sorted_insertion_event_table_top.sv
